// ===== hw/rtl/ncnm_pkg.sv =====
package ncnm_pkg;

   localparam int MaxColoursDefault   = 6;
   localparam int FractionBitsDefault = 16;
   localparam int RefSlots            = 6;
   localparam int SumWidth            = 16;
   localparam int TotalWidth          = 18;
   localparam int ChromaWidth         = 16;
   localparam int DistWidth           = 34;
   localparam int IndexWidth          = 3;
   localparam int CountWidth          = 3;
   localparam int CsrDataWidth        = 48;
   localparam int CsrIndexWidth       = 3;

   localparam logic [CsrIndexWidth-1:0] CsrColoursInUse = 3'd0;
   localparam logic [CountWidth-1:0]    ColoursResetVal = 3'd6;

   typedef struct packed {
      logic                  valid;
      logic                  nonzero;
      logic [CountWidth-1:0] count;
   } ctl_type;

endpackage

// ===== hw/rtl/ncnm_divider.sv =====
// Pipelined restoring divider: one quotient bit per stage.
// Computes min((part << FRAC) / total, 2^FRAC - 1); total is nonzero when used.
module ncnm_divider #(
   parameter int FRACTION_BITS = ncnm_pkg::FractionBitsDefault
) (
   input  logic                                 clock,
   input  logic                                 advance,
   input  logic [ncnm_pkg::SumWidth-1:0]        part,
   input  logic [ncnm_pkg::TotalWidth-1:0]      total,
   output logic [ncnm_pkg::ChromaWidth-1:0]     quotient
);
   localparam int Tw    = ncnm_pkg::TotalWidth;
   localparam int Steps = ncnm_pkg::SumWidth + FRACTION_BITS;
   localparam int Qw    = Steps;

   // Stage s holds the remainder, remaining dividend bits and quotient so far.
   logic [Tw-1:0]          rem_ff [1:Steps];
   logic [Steps-1:0]       dvd_ff [1:Steps];
   logic [Tw-1:0]          den_ff [1:Steps];
   logic [Qw-1:0]          quo_ff [1:Steps];

   for (genvar s = 0; s < Steps; s++) begin : g_stage
      logic [Tw-1:0]    rem_cur;
      logic [Steps-1:0] dvd_cur;
      logic [Tw-1:0]    den_cur;
      logic [Qw-1:0]    quo_cur;
      logic [Tw:0]      trial;
      logic [Tw+1:0]    diff;
      if (s == 0) begin : g_first
         assign rem_cur = '0;
         assign dvd_cur = {part, {FRACTION_BITS{1'b0}}};
         assign den_cur = total;
         assign quo_cur = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[s];
         assign dvd_cur = dvd_ff[s];
         assign den_cur = den_ff[s];
         assign quo_cur = quo_ff[s];
      end
      // The remainder stays below the divisor, so it always fits Tw bits.
      assign trial = {rem_cur, dvd_cur[Steps-1]};
      assign diff  = {1'b0, trial} - {2'b00, den_cur};
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[s+1] <= diff[Tw+1] ? trial[Tw-1:0] : diff[Tw-1:0];
            dvd_ff[s+1] <= {dvd_cur[Steps-2:0], 1'b0};
            den_ff[s+1] <= den_cur;
            quo_ff[s+1] <= {quo_cur[Qw-2:0], ~diff[Tw+1]};
         end
      end
   end

   localparam logic [Qw-1:0] One = Qw'(1) << FRACTION_BITS;
   assign quotient = (quo_ff[Steps] >= One) ? ncnm_pkg::ChromaWidth'(One - Qw'(1))
                                           : quo_ff[Steps][ncnm_pkg::ChromaWidth-1:0];
endmodule

// ===== hw/rtl/ncnm_lane.sv =====
// One distance lane: squared differences registered, then summed.
module ncnm_lane (
   input  logic                              clock,
   input  logic                              advance,
   input  logic [ncnm_pkg::ChromaWidth-1:0]  cr,
   input  logic [ncnm_pkg::ChromaWidth-1:0]  cg,
   input  logic [ncnm_pkg::ChromaWidth-1:0]  cb,
   input  logic [ncnm_pkg::CsrDataWidth-1:0] ref_colour,
   output logic [ncnm_pkg::DistWidth-1:0]    distance
);
   localparam int Cw = ncnm_pkg::ChromaWidth;
   logic [Cw-1:0]   dr, dg, db;
   logic [2*Cw-1:0] sr_ff, sg_ff, sb_ff;

   function automatic logic [Cw-1:0] absdiff(logic [Cw-1:0] a, logic [Cw-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   assign dr = absdiff(cr, ref_colour[15:0]);
   assign dg = absdiff(cg, ref_colour[31:16]);
   assign db = absdiff(cb, ref_colour[47:32]);

   always_ff @(posedge clock) begin
      if (advance) begin
         sr_ff <= (2*Cw)'(dr) * (2*Cw)'(dr);
         sg_ff <= (2*Cw)'(dg) * (2*Cw)'(dg);
         sb_ff <= (2*Cw)'(db) * (2*Cw)'(db);
      end
   end

   assign distance = {2'b00, sr_ff} + {2'b00, sg_ff} + {2'b00, sb_ff};
endmodule

// ===== hw/rtl/ncnm_merge.sv =====
// Picks the first strictly smallest distance among the lanes in use.
module ncnm_merge #(
   parameter int MAX_COLOURS = ncnm_pkg::MaxColoursDefault
) (
   input  logic [ncnm_pkg::DistWidth-1:0]  distance [MAX_COLOURS],
   input  logic [ncnm_pkg::CountWidth-1:0] count,
   input  logic                            nonzero,
   output logic                            matched,
   output logic [ncnm_pkg::IndexWidth-1:0] colour_index,
   output logic [ncnm_pkg::DistWidth-1:0]  best_distance
);
   always_comb begin
      matched       = 1'b0;
      colour_index  = '0;
      best_distance = '0;
      for (int i = 0; i < MAX_COLOURS; i++) begin
         if (nonzero && (ncnm_pkg::CountWidth'(i) < count) &&
             (!matched || distance[i] < best_distance)) begin
            matched       = 1'b1;
            colour_index  = ncnm_pkg::IndexWidth'(i);
            best_distance = distance[i];
         end
      end
   end
endmodule

// ===== hw/rtl/normalized_colour_nearest_match.sv =====
// Pipeline: SumWidth + FRACTION_BITS divider stages, one squaring stage and one
// merge/output stage. Throughput: one reading per cycle unless the output is
// held; the divider is fully pipelined, one quotient bit per stage, and the
// lanes compare all colours in parallel.
// Reset: synchronous, active high; clears valid flags, colours_in_use to 6
// and all reference colours to zero.
module normalized_colour_nearest_match #(
   parameter int MAX_COLOURS   = ncnm_pkg::MaxColoursDefault,
   parameter int FRACTION_BITS = ncnm_pkg::FractionBitsDefault
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [ncnm_pkg::SumWidth-1:0]         req_red_sum,
   input  logic [ncnm_pkg::SumWidth-1:0]         req_green_sum,
   input  logic [ncnm_pkg::SumWidth-1:0]         req_blue_sum,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_matched,
   output logic [ncnm_pkg::IndexWidth-1:0]       rsp_colour_index,
   output logic [ncnm_pkg::DistWidth-1:0]        rsp_best_distance,
   input  logic                                  csr_write_enable,
   input  logic [ncnm_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [ncnm_pkg::CsrDataWidth-1:0]     csr_write_data
);
   localparam int Depth = ncnm_pkg::SumWidth + FRACTION_BITS + 1;
   localparam int Cw    = ncnm_pkg::CountWidth;

   logic [Cw-1:0]                     colours_ff;
   logic [ncnm_pkg::CsrDataWidth-1:0] ref_ff [MAX_COLOURS];

   always_ff @(posedge clock) begin
      if (reset) begin
         colours_ff <= ncnm_pkg::ColoursResetVal;
         for (int i = 0; i < MAX_COLOURS; i++) ref_ff[i] <= '0;
      end else if (csr_write_enable) begin
         if (csr_index == ncnm_pkg::CsrColoursInUse) begin
            colours_ff <= csr_write_data[Cw-1:0];
         end
         for (int i = 0; i < MAX_COLOURS; i++) begin
            if (csr_index == ncnm_pkg::CsrIndexWidth'(i + 1)) ref_ff[i] <= csr_write_data;
         end
      end
   end

   // The whole pipeline stalls together when the output register is held.
   logic advance;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   logic [ncnm_pkg::TotalWidth-1:0] total;
   assign total = {2'b00, req_red_sum} + {2'b00, req_green_sum} + {2'b00, req_blue_sum};

   ncnm_pkg::ctl_type ctl_ff [Depth];
   ncnm_pkg::ctl_type ctl_in;
   always_comb begin
      ctl_in.valid   = req_valid;
      ctl_in.nonzero = (total != '0);
      ctl_in.count   = (colours_ff > Cw'(MAX_COLOURS)) ? Cw'(MAX_COLOURS) : colours_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Depth; i++) ctl_ff[i] <= '0;
      end else if (advance) begin
         ctl_ff[0] <= ctl_in;
         for (int i = 1; i < Depth; i++) ctl_ff[i] <= ctl_ff[i-1];
      end
   end

   logic [ncnm_pkg::ChromaWidth-1:0] cr, cg, cb;
   // A zero total is replaced by one so the divider never sees zero.
   logic [ncnm_pkg::TotalWidth-1:0] divisor;
   assign divisor = (total == '0) ? ncnm_pkg::TotalWidth'(1) : total;

   ncnm_divider #(.FRACTION_BITS(FRACTION_BITS)) u_div_r (
      .clock(clock), .advance(advance), .part(req_red_sum), .total(divisor), .quotient(cr));
   ncnm_divider #(.FRACTION_BITS(FRACTION_BITS)) u_div_g (
      .clock(clock), .advance(advance), .part(req_green_sum), .total(divisor), .quotient(cg));
   ncnm_divider #(.FRACTION_BITS(FRACTION_BITS)) u_div_b (
      .clock(clock), .advance(advance), .part(req_blue_sum), .total(divisor), .quotient(cb));

   logic [ncnm_pkg::DistWidth-1:0] distance [MAX_COLOURS];
   for (genvar l = 0; l < MAX_COLOURS; l++) begin : g_lane
      ncnm_lane u_lane (
         .clock(clock), .advance(advance), .cr(cr), .cg(cg), .cb(cb),
         .ref_colour(ref_ff[l]), .distance(distance[l]));
   end

   logic                            m_matched;
   logic [ncnm_pkg::IndexWidth-1:0] m_index;
   logic [ncnm_pkg::DistWidth-1:0]  m_dist;
   ncnm_merge #(.MAX_COLOURS(MAX_COLOURS)) u_merge (
      .distance(distance), .count(ctl_ff[Depth-1].count), .nonzero(ctl_ff[Depth-1].nonzero),
      .matched(m_matched), .colour_index(m_index), .best_distance(m_dist));

   logic                            valid_ff;
   logic                            matched_ff;
   logic [ncnm_pkg::IndexWidth-1:0] index_ff;
   logic [ncnm_pkg::DistWidth-1:0]  dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= ctl_ff[Depth-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         matched_ff <= m_matched;
         index_ff   <= m_index;
         dist_ff    <= m_dist;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_matched       = matched_ff;
   assign rsp_colour_index  = index_ff;
   assign rsp_best_distance = dist_ff;
endmodule
